[rtl/fbfl_pkg.sv]
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared constants and types of the fixed-size block free-list allocator:
// action and status codes, register indexes, field widths and defaults.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF          = 1024;
    localparam int MIN_SLOT_BYTES_DEF = 8;

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int SIZE_W    = 16;
    localparam int INDEX_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 26;
    localparam int COUNT_W   = 11;
    localparam int BYTES_W   = 17;
    localparam int PROD_W    = COUNT_W + BYTES_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REBUILD = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'd1;

    // Configuration reset values
    localparam logic [SIZE_W-1:0]  SLOT_BYTES_RST   = 16'd8;
    localparam logic [COUNT_W-1:0] SLOTS_IN_USE_RST = 11'd1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Link memory port controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

[rtl/fbfl_link_mem.sv]
// ----------------------------------------------------------------------------
// fbfl_link_mem
// Single-port-write, single-port-read link memory holding the next pointer
// and continuation bit of each freed slot. Registered read.
// ----------------------------------------------------------------------------
module fbfl_link_mem #(
    parameter int DEPTH = fbfl_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = AW + 1
) (
    input  logic               clk,
    input  fbfl_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]      rd_addr,
    input  logic [AW-1:0]      wr_addr,
    input  logic [DW-1:0]      wr_data,
    output logic [DW-1:0]      rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fbfl_core.sv]
// ----------------------------------------------------------------------------
// fbfl_core
// Allocator sequencer: latches a transaction, reads the link memory at the
// free-list head, then updates the pool state and registers the result.
// ----------------------------------------------------------------------------
module fbfl_core #(
    parameter int SLOTS          = fbfl_pkg::SLOTS_DEF,
    parameter int MIN_SLOT_BYTES = fbfl_pkg::MIN_SLOT_BYTES_DEF,
    parameter int AW             = $clog2(SLOTS),
    parameter int DW             = AW + 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [fbfl_pkg::ACTION_W-1:0]   action,
    input  logic [fbfl_pkg::SIZE_W-1:0]     request_size,
    input  logic [fbfl_pkg::INDEX_W-1:0]    slot_index,
    input  logic [fbfl_pkg::SIZE_W-1:0]     cfg_slot_bytes,
    input  logic [fbfl_pkg::COUNT_W-1:0]    cfg_slots_in_use,
    output fbfl_pkg::mem_ctl_t              mem_ctl,
    output logic [AW-1:0]                   mem_rd_addr,
    output logic [AW-1:0]                   mem_wr_addr,
    output logic [DW-1:0]                   mem_wr_data,
    input  logic [DW-1:0]                   mem_rd_data,
    output logic                            done,
    output logic [fbfl_pkg::STATUS_W-1:0]   status,
    output logic [fbfl_pkg::INDEX_W-1:0]    granted_slot,
    output logic [fbfl_pkg::OFFSET_W-1:0]   byte_offset,
    output logic [fbfl_pkg::COUNT_W-1:0]    free_count
);

    localparam int CW = fbfl_pkg::COUNT_W;
    localparam int BW = fbfl_pkg::BYTES_W;
    localparam int MIN_EFF  = (MIN_SLOT_BYTES > 8) ? MIN_SLOT_BYTES : 8;
    localparam int POOL_RST = (SLOTS < 1024) ? SLOTS : 1024;
    localparam logic [BW-1:0] EFF_RST      = BW'(MIN_EFF);
    localparam logic [BW-1:0] MIN_BYTES    = BW'(MIN_SLOT_BYTES);
    localparam logic [CW-1:0] POOL_RST_VAL = CW'(POOL_RST);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [fbfl_pkg::ACTION_W-1:0] act_reg;
    logic [fbfl_pkg::SIZE_W-1:0]   req_reg;
    logic [fbfl_pkg::INDEX_W-1:0]  idx_reg;

    logic [AW-1:0] head_reg, head_next;
    logic          head_valid_reg, head_valid_next;
    logic [CW-1:0] watermark_reg, watermark_next;
    logic [CW-1:0] avail_reg, avail_next;
    logic [CW-1:0] pool_reg, pool_next;
    logic [BW-1:0] eff_reg, eff_next;

    logic                          done_reg;
    logic [fbfl_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [fbfl_pkg::INDEX_W-1:0]  granted_reg;
    logic [fbfl_pkg::OFFSET_W-1:0] offset_reg;

    logic [CW-1:0]                 grant_full;
    logic [fbfl_pkg::PROD_W-1:0]   product;
    logic                          accept;
    logic                          free_ok;
    logic [AW-1:0]                 link_next;
    logic                          link_more;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign link_next = mem_rd_data[AW-1:0];
    assign link_more = mem_rd_data[AW];

    // Read the head entry on every accept; only an allocate uses it.
    assign mem_ctl.rd_en = accept;
    assign mem_ctl.wr_en = (state_reg == ST_EXEC) && free_ok;
    assign mem_rd_addr   = head_reg;
    assign mem_wr_addr   = AW'(idx_reg);
    assign mem_wr_data   = {head_valid_reg, head_reg};

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        watermark_next  = watermark_reg;
        avail_next      = avail_reg;
        pool_next       = pool_reg;
        eff_next        = eff_reg;
        status_next     = fbfl_pkg::STAT_INVALID;
        grant_full      = '0;
        free_ok         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (act_reg)
                    fbfl_pkg::ACT_ALLOC:
                    begin
                        if (BW'(req_reg) > eff_reg)
                        begin
                            status_next = fbfl_pkg::STAT_INVALID;
                        end
                        else if (head_valid_reg)
                        begin
                            grant_full      = CW'(head_reg);
                            head_next       = link_next;
                            head_valid_next = link_more;
                            status_next     = fbfl_pkg::STAT_OK;
                        end
                        else if (watermark_reg < pool_reg)
                        begin
                            grant_full     = watermark_reg;
                            watermark_next = watermark_reg + CW'(1);
                            status_next    = fbfl_pkg::STAT_OK;
                        end
                        else
                        begin
                            status_next = fbfl_pkg::STAT_EMPTY;
                        end
                        if (status_next == fbfl_pkg::STAT_OK && avail_reg != '0)
                        begin
                            avail_next = avail_reg - CW'(1);
                        end
                    end
                    fbfl_pkg::ACT_FREE:
                    begin
                        if (CW'(idx_reg) < pool_reg && 32'(idx_reg) < SLOTS)
                        begin
                            free_ok         = 1'b1;
                            head_next       = AW'(idx_reg);
                            head_valid_next = 1'b1;
                            status_next     = fbfl_pkg::STAT_OK;
                            if (avail_reg != fbfl_pkg::COUNT_MAX)
                            begin
                                avail_next = avail_reg + CW'(1);
                            end
                        end
                    end
                    fbfl_pkg::ACT_REBUILD:
                    begin
                        if (cfg_slot_bytes != '0 && cfg_slots_in_use != '0 &&
                            32'(cfg_slots_in_use) <= SLOTS)
                        begin
                            eff_next = (BW'(cfg_slot_bytes) < MIN_BYTES) ?
                                       MIN_BYTES : BW'(cfg_slot_bytes);
                            pool_next       = cfg_slots_in_use;
                            avail_next      = cfg_slots_in_use;
                            watermark_next  = '0;
                            head_next       = '0;
                            head_valid_next = 1'b0;
                            status_next     = fbfl_pkg::STAT_OK;
                        end
                    end
                    default:
                    begin
                        status_next = fbfl_pkg::STAT_INVALID;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign product = grant_full * eff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            watermark_reg  <= '0;
            avail_reg      <= POOL_RST_VAL;
            pool_reg       <= POOL_RST_VAL;
            eff_reg        <= EFF_RST;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            watermark_reg  <= watermark_next;
            avail_reg      <= avail_next;
            pool_reg       <= pool_next;
            eff_reg        <= eff_next;
            done_reg       <= (state_reg == ST_EXEC);
        end
    end

    // Transaction and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            req_reg <= request_size;
            idx_reg <= slot_index;
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg  <= status_next;
            granted_reg <= grant_full[fbfl_pkg::INDEX_W-1:0];
            offset_reg  <= product[fbfl_pkg::OFFSET_W-1:0];
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign byte_offset  = offset_reg;
    assign free_count   = avail_reg;

endmodule

[rtl/fixed_block_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// Pool allocator of equal-size slots with a LIFO free list kept in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. action selects allocate, free or rebuild; request_size and
//   slot_index carry the operands.
//   Result channel: done is high for exactly one cycle with status,
//   granted_slot, byte_offset and free_count; it cannot be held off.
//   Timing: busy is high in the execute state that follows the accept edge,
//   and done follows in the next cycle; a new command is not taken while
//   busy is high. The execute state uses the registered read of the link
//   memory at the free-list head, whose result an allocate needs.
//   Configuration: cfg_we writes cfg_data into register cfg_index (slot
//   size, slot count) at the clock edge; a rebuild command applies them.
//   Reset: pool has max(MIN_SLOT_BYTES, 8)-byte slots and min(SLOTS, 1024)
//   slots, all slots free. The link memory is not cleared; only entries
//   pushed since the last rebuild are read. No result is pending after reset.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top #(
    parameter int SLOTS          = fbfl_pkg::SLOTS_DEF,
    parameter int MIN_SLOT_BYTES = fbfl_pkg::MIN_SLOT_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [fbfl_pkg::ACTION_W-1:0]    action,
    input  logic [fbfl_pkg::SIZE_W-1:0]      request_size,
    input  logic [fbfl_pkg::INDEX_W-1:0]     slot_index,
    input  logic                             cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbfl_pkg::CFG_DAT_W-1:0]   cfg_data,
    output logic                             done,
    output logic [fbfl_pkg::STATUS_W-1:0]    status,
    output logic [fbfl_pkg::INDEX_W-1:0]     granted_slot,
    output logic [fbfl_pkg::OFFSET_W-1:0]    byte_offset,
    output logic [fbfl_pkg::COUNT_W-1:0]     free_count
);

    localparam int AW = $clog2(SLOTS);
    localparam int DW = AW + 1;

    logic [fbfl_pkg::SIZE_W-1:0]  slot_bytes_reg;
    logic [fbfl_pkg::COUNT_W-1:0] slots_in_use_reg;

    fbfl_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]      mem_rd_addr;
    logic [AW-1:0]      mem_wr_addr;
    logic [DW-1:0]      mem_wr_data;
    logic [DW-1:0]      mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bytes_reg   <= fbfl_pkg::SLOT_BYTES_RST;
            slots_in_use_reg <= fbfl_pkg::SLOTS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fbfl_pkg::REG_SLOT_BYTES:
                begin
                    slot_bytes_reg <= cfg_data;
                end
                fbfl_pkg::REG_SLOTS_IN_USE:
                begin
                    slots_in_use_reg <= cfg_data[fbfl_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    slot_bytes_reg <= slot_bytes_reg;
                end
            endcase
        end
    end

    fbfl_core #(
        .SLOTS          (SLOTS),
        .MIN_SLOT_BYTES (MIN_SLOT_BYTES),
        .AW             (AW),
        .DW             (DW)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .request_size     (request_size),
        .slot_index       (slot_index),
        .cfg_slot_bytes   (slot_bytes_reg),
        .cfg_slots_in_use (slots_in_use_reg),
        .mem_ctl          (mem_ctl),
        .mem_rd_addr      (mem_rd_addr),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_data      (mem_rd_data),
        .done             (done),
        .status           (status),
        .granted_slot     (granted_slot),
        .byte_offset      (byte_offset),
        .free_count       (free_count)
    );

    fbfl_link_mem #(
        .DEPTH (SLOTS),
        .AW    (AW),
        .DW    (DW)
    ) u_link_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    // An accepted transaction raises busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("result strobe missing after execute cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != fbfl_pkg::STAT_OK) |-> (granted_slot == '0 && byte_offset == '0))
        else $error("failed transaction reports a slot");

endmodule
